// File: src/aminv_pkg.sv
package aminv_pkg;

	localparam int QW = 32;
	localparam int CW = 64;
	localparam int DW = 97;
	localparam int MW = 96;
	localparam int QB = 33;
	localparam int DET_LAT = 5;
	localparam int DIV_LAT = QB + 3;
	localparam int XL_LAT = 3;
	localparam int IN_W = 12 * QW;
	localparam int OUT_W = 3 * QW;
	localparam int USER_W = 4;

	typedef logic signed [QW-1:0] fx_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic signed [DW-1:0] det_t;

	typedef enum logic [1:0] {
		ROW_1 = 2'd0,
		ROW_2 = 2'd1,
		ROW_3 = 2'd2,
		ROW_T = 2'd3
	} row_t;

	typedef struct packed {
		logic            sing;
		fx_t [8:0]       inv;
		logic [2:0]      ovf;
		fx_t [2:0]       xl;
		logic            xovf;
	} res_t;

	// operand pairs of the eighteen cofactor products, source order a11..a33
	localparam int PA [18] = '{4, 5, 2, 1, 1, 2, 6, 3, 0, 6, 3, 0, 3, 6, 6, 0, 0, 3};
	localparam int PB [18] = '{8, 7, 7, 8, 5, 4, 5, 8, 8, 2, 2, 5, 7, 4, 1, 7, 4, 1};

	localparam fx_t FX_MAX = 32'sh7FFF_FFFF;
	localparam fx_t FX_MIN = 32'sh8000_0000;

endpackage

// File: src/affine_matrix_inverse_top.sv
// Inverts an affine matrix given as its 3x3 linear part and translation row in signed Q16.16.
// A request enters a 44-stage pipeline (five stages of cofactors and determinant, 36 of
// division with 33 restoring steps at one quotient bit each, three of translation) and may
// enter every cycle while the pipeline moves. Each regular matrix leaves as four rows, one per
// cycle while m_tready is high, so the output port, not the pipeline, sets the sustained rate;
// a singular matrix leaves as a single row flagged singular. A stall on the result side
// freezes the whole pipeline while a finished result waits at its end.
module affine_matrix_inverse_top
	import aminv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // a11 a12 a13 a21 a22 a23 a31 a32 a33 tx ty tz
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,   // out_first out_second out_third
	output logic [USER_W-1:0] m_tuser,   // row_index[1:0] singular overflow
	output logic              m_tlast
);

	localparam int SIDE = DET_LAT + DIV_LAT;

	logic       en;
	fx_t        a [9];
	fx_t [2:0]  t_line [SIDE];
	fx_t        t_xl [3];
	logic       det_v, div_v, xl_v, ser_ready;
	cof_t       cof [9];
	det_t       det;
	fx_t        inv [9];
	logic [8:0] dovf;
	logic       dzero;
	logic [2:0] iovf;
	res_t       res;

	assign en = !xl_v || ser_ready;
	assign s_tready = en;

	for (genvar i = 0; i < 9; i++) begin : g_in
		assign a[i] = s_tdata[QW*i +: QW];
	end

	// translation waits beside the determinant and division stages
	always_ff @(posedge clk) begin
		if (en) begin
			t_line[0] <= s_tdata[IN_W-1:9*QW];
			for (int i = 1; i < SIDE; i++) begin
				t_line[i] <= t_line[i-1];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_t
		assign t_xl[i] = t_line[SIDE-1][i];
	end

	aminv_det u_det (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.a         (a),
		.out_valid (det_v),
		.cof       (cof),
		.det       (det)
	);

	for (genvar k = 0; k < 9; k++) begin : g_div
		if (k == 0) begin : g_lead
			aminv_div u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (det_v),
				.cof       (cof[k]),
				.det       (det),
				.out_valid (div_v),
				.q         (inv[k]),
				.ovf       (dovf[k]),
				.zero      (dzero)
			);
		end else begin : g_rest
			aminv_div u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (det_v),
				.cof       (cof[k]),
				.det       (det),
				.out_valid (),
				.q         (inv[k]),
				.ovf       (dovf[k]),
				.zero      ()
			);
		end
	end

	assign iovf = {|dovf[8:6], |dovf[5:3], |dovf[2:0]};

	aminv_xlat u_xlat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (div_v),
		.t         (t_xl),
		.inv       (inv),
		.iovf      (iovf),
		.zero_in   (dzero),
		.out_valid (xl_v),
		.res       (res)
	);

	aminv_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (xl_v),
		.res      (res),
		.in_ready (ser_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_sing_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast && (m_tdata == '0) && (m_tuser[1:0] == ROW_1))
		else $error("singular result not a lone zero row");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1))
		else $error("rows of one matrix not consecutive");

	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> (m_tlast == (m_tuser[1:0] == ROW_T)))
		else $error("last flag not on translation row");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		xl_v && !ser_ready |=> xl_v && $stable(res))
		else $error("pipeline result lost under stall");

endmodule

// File: src/aminv_det.sv
module aminv_det
	import aminv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  fx_t  a [9],
	output logic out_valid,
	output cof_t cof [9],
	output det_t det
);

	logic signed [CW-1:0] p_s1 [18];
	fx_t                  c_s1 [3];
	cof_t                 cof_s2 [9];
	fx_t                  c_s2 [3];
	logic signed [CW:0]   pl_s3 [3];
	logic signed [CW-1:0] ph_s3 [3];
	cof_t                 cof_s3 [9];
	det_t                 tm_s4 [3];
	cof_t                 cof_s4 [9];
	det_t                 det_s5;
	cof_t                 cof_s5 [9];
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 18; i++) begin
				p_s1[i] <= a[PA[i]] * a[PB[i]];
			end
			c_s1[0] <= a[0];
			c_s1[1] <= a[3];
			c_s1[2] <= a[6];

			for (int k = 0; k < 9; k++) begin
				cof_s2[k] <= p_s1[2*k] - p_s1[2*k+1];
			end
			c_s2 <= c_s1;

			// split the 64-bit cofactor so each multiply stays near 32x32
			for (int k = 0; k < 3; k++) begin
				pl_s3[k] <= c_s2[k] * $signed({1'b0, cof_s2[k][31:0]});
				ph_s3[k] <= c_s2[k] * $signed(cof_s2[k][63:32]);
			end
			cof_s3 <= cof_s2;

			for (int k = 0; k < 3; k++) begin
				tm_s4[k] <= (DW'(ph_s3[k]) <<< 32) + DW'(pl_s3[k]);
			end
			cof_s4 <= cof_s3;

			det_s5 <= tm_s4[0] + tm_s4[1] + tm_s4[2];
			cof_s5 <= cof_s4;
		end
	end

	assign out_valid = v_s5;
	assign cof = cof_s5;
	assign det = det_s5;

endmodule

// File: src/aminv_div.sv
module aminv_div
	import aminv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  cof_t cof,
	input  det_t det,
	output logic out_valid,
	output fx_t  q,
	output logic ovf,
	output logic zero
);

	logic [CW-1:0] mc_s1;
	logic [MW-1:0] md_s1;
	logic          neg_s1, v_s1;
	logic          lsb_s2;

	logic [MW-1:0] rem_s  [QB+1];
	logic [QB-1:0] quo_s  [QB+1];
	logic [MW-1:0] md_s   [QB+1];
	logic          neg_s  [QB+1];
	logic          big_s  [QB+1];
	logic          zero_s [QB+1];
	logic          v_s    [QB+1];

	fx_t  q_so;
	logic ovf_so, zero_so, v_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s[0] <= 1'b0;
			v_so <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s[0] <= v_s1;
			v_so <= v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mc_s1 <= cof[CW-1] ? CW'(-cof) : CW'(cof);
			md_s1 <= det[DW-1] ? MW'(-det) : MW'(det);
			neg_s1 <= cof[CW-1] ^ det[DW-1];

			// quotient of 2^33 or more saturates whatever its sign
			big_s[0] <= {33'd0, mc_s1[CW-1:1]} >= md_s1;
			rem_s[0] <= MW'(mc_s1[CW-1:1]);
			lsb_s2 <= mc_s1[0];
			quo_s[0] <= '0;
			md_s[0] <= md_s1;
			neg_s[0] <= neg_s1;
			zero_s[0] <= (md_s1 == '0);
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic          nb;
		logic [MW:0]   sh;
		logic [MW:0]   df;
		logic          ge;

		assign nb = (k == 0) ? lsb_s2 : 1'b0;
		assign sh = {rem_s[k], nb};
		assign df = sh - {1'b0, md_s[k]};
		assign ge = (sh >= {1'b0, md_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? df[MW-1:0] : sh[MW-1:0];
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge};
				md_s[k+1] <= md_s[k];
				neg_s[k+1] <= neg_s[k];
				big_s[k+1] <= big_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	logic [QB-1:0] qf;
	logic          ng;
	fx_t           qv;
	logic          qo;

	assign qf = quo_s[QB];
	assign ng = neg_s[QB] && (big_s[QB] || (qf != '0));

	always_comb begin
		qo = 1'b0;
		qv = QW'(qf);
		if (big_s[QB]) begin
			qo = 1'b1;
			qv = ng ? FX_MIN : FX_MAX;
		end else if (!ng) begin
			if (qf[QB-1] || qf[QB-2]) begin
				qo = 1'b1;
				qv = FX_MAX;
			end
		end else if (qf > {1'b0, FX_MIN}) begin
			qo = 1'b1;
			qv = FX_MIN;
		end else begin
			qv = QW'(-qf);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_so <= qv;
			ovf_so <= qo;
			zero_so <= zero_s[QB];
		end
	end

	assign out_valid = v_so;
	assign q = q_so;
	assign ovf = ovf_so;
	assign zero = zero_so;

endmodule

// File: src/aminv_xlat.sv
module aminv_xlat
	import aminv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  fx_t        t [3],
	input  fx_t        inv [9],
	input  logic [2:0] iovf,
	input  logic       zero_in,
	output logic       out_valid,
	output res_t       res
);

	logic signed [CW-1:0] p_s1 [9];
	logic signed [CW+1:0] s_s2 [3];
	fx_t                  inv_s1 [9], inv_s2 [9];
	logic [2:0]           iovf_s1, iovf_s2;
	logic                 zero_s1, zero_s2;
	logic                 v_s1, v_s2, v_s3;
	res_t                 res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	logic [CW+1:0] mg  [3];
	logic [CW-15:0] m  [3];
	logic          ng  [3];
	fx_t           xv  [3];
	logic [2:0]    xo;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mg[j] = s_s2[j][CW+1] ? (CW+2)'(-s_s2[j]) : (CW+2)'(s_s2[j]);
			m[j] = mg[j][CW+1:16];
			ng[j] = s_s2[j][CW+1] && (m[j] != '0);
			xo[j] = 1'b0;
			xv[j] = QW'(m[j]);
			if (!ng[j]) begin
				if (m[j] > (CW-14)'(FX_MAX)) begin
					xo[j] = 1'b1;
					xv[j] = FX_MAX;
				end
			end else if (m[j] > (CW-14)'({1'b0, FX_MIN})) begin
				xo[j] = 1'b1;
				xv[j] = FX_MIN;
			end else begin
				xv[j] = QW'(-m[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					p_s1[r*3+j] <= t[r] * inv[r*3+j];
				end
			end
			inv_s1 <= inv;
			iovf_s1 <= iovf;
			zero_s1 <= zero_in;

			for (int j = 0; j < 3; j++) begin
				s_s2[j] <= -((CW+2)'(p_s1[j]) + (CW+2)'(p_s1[3+j]) + (CW+2)'(p_s1[6+j]));
			end
			inv_s2 <= inv_s1;
			iovf_s2 <= iovf_s1;
			zero_s2 <= zero_s1;

			res_s3.sing <= zero_s2;
			for (int i = 0; i < 9; i++) begin
				res_s3.inv[i] <= inv_s2[i];
			end
			res_s3.ovf <= iovf_s2;
			for (int j = 0; j < 3; j++) begin
				res_s3.xl[j] <= xv[j];
			end
			res_s3.xovf <= |xo;
		end
	end

	assign out_valid = v_s3;
	assign res = res_s3;

endmodule

// File: src/aminv_ser.sv
module aminv_ser
	import aminv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  res_t              res,
	output logic              in_ready,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,
	output logic [USER_W-1:0] m_tuser,
	output logic              m_tlast
);

	logic busy_q;
	row_t idx_q;
	res_t res_q;
	logic last_row;

	assign last_row = res_q.sing || (idx_q == ROW_T);
	assign in_ready = !busy_q || (m_tready && last_row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= ROW_1;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			idx_q <= ROW_1;
		end else if (busy_q && m_tready) begin
			if (last_row) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= row_t'(idx_q + 2'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= res;
		end
	end

	always_comb begin
		m_tdata = '0;
		m_tuser = {1'b0, 1'b1, ROW_1};
		if (!res_q.sing) begin
			case (idx_q)
				ROW_1: begin
					m_tdata = {res_q.inv[2], res_q.inv[1], res_q.inv[0]};
					m_tuser = {res_q.ovf[0], 1'b0, ROW_1};
				end
				ROW_2: begin
					m_tdata = {res_q.inv[5], res_q.inv[4], res_q.inv[3]};
					m_tuser = {res_q.ovf[1], 1'b0, ROW_2};
				end
				ROW_3: begin
					m_tdata = {res_q.inv[8], res_q.inv[7], res_q.inv[6]};
					m_tuser = {res_q.ovf[2], 1'b0, ROW_3};
				end
				ROW_T: begin
					m_tdata = {res_q.xl[2], res_q.xl[1], res_q.xl[0]};
					m_tuser = {res_q.xovf, 1'b0, ROW_T};
				end
				default: begin
					m_tdata = '0;
				end
			endcase
		end
	end

	assign m_tvalid = busy_q;
	assign m_tlast = last_row;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import aminv_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		row_t row;
		fx_t  c1;
		fx_t  c2;
		fx_t  c3;
		logic sing;
		logic ovf;
		logic lst;
	} inv_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_W-1:0]  m_tdata;
	logic [USER_W-1:0] m_tuser;
	logic              m_tlast;

	logic [IN_W-1:0] matrix_q[$];
	inv_row_t        inverse_rows_q[$];
	int              sent_cnt;
	int              quiet_cnt;
	bit              failed;

	affine_matrix_inverse_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// no idling on either side while this window of requests goes through
	function automatic bit calm();
		return sent_cnt >= 120 && sent_cnt < 200;
	endfunction

	// magnitude and sign to saturated q16.16, overflow flag on top
	function automatic logic [32:0] clip(logic [127:0] mag, logic neg);
		logic [31:0] low;
		low = mag[31:0];
		if (!neg) begin
			if (mag > 128'h7FFF_FFFF)
				return {1'b1, FX_MAX};
			return {1'b0, low};
		end
		if (mag > 128'h8000_0000)
			return {1'b1, FX_MIN};
		return {1'b0, 32'd0 - low};
	endfunction

	function automatic void predict_inverse(logic [IN_W-1:0] req);
		logic signed [127:0] a[9];
		logic signed [127:0] t[3];
		logic signed [127:0] c[9];
		logic signed [127:0] det;
		logic signed [127:0] s;
		logic signed [127:0] iv;
		logic [127:0] mdet;
		logic [127:0] mag;
		logic [127:0] q;
		logic [32:0] r;
		fx_t inv[9];
		fx_t xl[3];
		logic [3:0] ov;
		logic dneg;
		inv_row_t e;
		for (int i = 0; i < 9; i++)
			a[i] = $signed(req[i*QW +: QW]);
		for (int i = 0; i < 3; i++)
			t[i] = $signed(req[(9+i)*QW +: QW]);
		c[0] = a[4]*a[8] - a[5]*a[7];
		c[1] = a[2]*a[7] - a[1]*a[8];
		c[2] = a[1]*a[5] - a[2]*a[4];
		c[3] = a[6]*a[5] - a[3]*a[8];
		c[4] = a[0]*a[8] - a[6]*a[2];
		c[5] = a[3]*a[2] - a[0]*a[5];
		c[6] = a[3]*a[7] - a[6]*a[4];
		c[7] = a[6]*a[1] - a[0]*a[7];
		c[8] = a[0]*a[4] - a[3]*a[1];
		det = a[0]*c[0] + a[3]*c[1] + a[6]*c[2];
		if (det == 0) begin
			e = '{ROW_1, '0, '0, '0, 1'b1, 1'b0, 1'b1};
			inverse_rows_q.push_back(e);
			return;
		end
		dneg = det[127];
		mdet = dneg ? -det : det;
		ov = '0;
		for (int i = 0; i < 9; i++) begin
			mag = c[i][127] ? -c[i] : c[i];
			q = (mag << 32) / mdet;
			r = clip(q, (c[i][127] != dneg) && q != 0);
			inv[i] = r[31:0];
			ov[i/3] |= r[32];
		end
		for (int j = 0; j < 3; j++) begin
			s = 0;
			for (int k = 0; k < 3; k++) begin
				iv = inv[k*3+j];
				s += t[k] * iv;
			end
			s = -s;
			mag = s[127] ? -s : s;
			mag = mag >> 16;
			r = clip(mag, s[127] && mag != 0);
			xl[j] = r[31:0];
			ov[3] |= r[32];
		end
		for (int i = 0; i < 3; i++) begin
			e = '{row_t'(i), inv[i*3], inv[i*3+1], inv[i*3+2], 1'b0, ov[i], 1'b0};
			inverse_rows_q.push_back(e);
		end
		e = '{ROW_T, xl[0], xl[1], xl[2], 1'b0, ov[3], 1'b1};
		inverse_rows_q.push_back(e);
	endfunction

	function automatic logic [IN_W-1:0] pack(fx_t m[12]);
		logic [IN_W-1:0] v;
		for (int i = 0; i < 12; i++)
			v[i*QW +: QW] = m[i];
		return v;
	endfunction

	function automatic fx_t rnd_fx(int scale);
		case (scale)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
			2: return $signed($urandom_range(0, 32'h200)) - 32'sh100;
			default: return $signed($urandom_range(0, 32'h80_0000)) - 32'sh40_0000;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			sent_cnt <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (matrix_q.size() > 0 && (calm() || $urandom_range(99) >= 17)) begin
				s_tdata <= matrix_q[0];
				predict_inverse(matrix_q.pop_front());
				s_tvalid <= 1'b1;
				sent_cnt <= sent_cnt + 1;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		inv_row_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm() || $urandom_range(99) >= 17;
			if (m_tvalid && m_tready) begin
				if (inverse_rows_q.size() == 0) begin
					$error("unexpected result row %0d", m_tuser[1:0]);
					failed = 1'b1;
				end else begin
					e = inverse_rows_q.pop_front();
					if (m_tuser[1:0] != e.row) begin
						$error("row_index: expected %0d, got %0d", e.row, m_tuser[1:0]);
						failed = 1'b1;
					end
					if (m_tdata[31:0] != e.c1) begin
						$error("out_first: expected %h, got %h", e.c1, m_tdata[31:0]);
						failed = 1'b1;
					end
					if (m_tdata[63:32] != e.c2) begin
						$error("out_second: expected %h, got %h", e.c2, m_tdata[63:32]);
						failed = 1'b1;
					end
					if (m_tdata[95:64] != e.c3) begin
						$error("out_third: expected %h, got %h", e.c3, m_tdata[95:64]);
						failed = 1'b1;
					end
					if (m_tuser[2] != e.sing) begin
						$error("singular: expected %b, got %b", e.sing, m_tuser[2]);
						failed = 1'b1;
					end
					if (m_tuser[3] != e.ovf) begin
						$error("overflow: expected %b, got %b", e.ovf, m_tuser[3]);
						failed = 1'b1;
					end
					if (m_tlast != e.lst) begin
						$error("last: expected %b, got %b", e.lst, m_tlast);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cnt <= 0;
		end else begin
			quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		fx_t m[12];
		int kind;
		arst_n = 1'b0;

		// identity, with translation
		m = '{32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000,
			32'sh3_0000, -32'sh2_8000, 32'sh0_4000};
		matrix_q.push_back(pack(m));
		// negative identity, extreme translation
		m = '{-32'sh1_0000, 0, 0, 0, -32'sh1_0000, 0, 0, 0, -32'sh1_0000,
			FX_MAX, FX_MIN, FX_MAX};
		matrix_q.push_back(pack(m));
		// zero matrix
		m = '{default: 0};
		matrix_q.push_back(pack(m));
		// tiny diagonal, inverse saturates
		m = '{1, 0, 0, 0, 1, 0, 0, 0, -1, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000};
		matrix_q.push_back(pack(m));
		// all maximum, singular
		m = '{default: FX_MAX};
		matrix_q.push_back(pack(m));
		// all minimum, singular
		m = '{default: FX_MIN};
		matrix_q.push_back(pack(m));
		// extreme diagonal
		m = '{FX_MAX, 0, 0, 0, FX_MIN, 0, 0, 0, FX_MAX, FX_MIN, FX_MAX, -1};
		matrix_q.push_back(pack(m));
		m = '{FX_MIN, 1, 0, -1, FX_MIN, 0, 0, 0, FX_MIN, 1, -1, 0};
		matrix_q.push_back(pack(m));
		// permutation with scale
		m = '{0, 32'sh2_0000, 0, 0, 0, 32'sh0_8000, -32'sh4_0000, 0, 0,
			32'sh10_0000, 32'sh7FFF_0000, -32'sh7FFF_0000};
		matrix_q.push_back(pack(m));
		// duplicate rows
		m = '{32'sh1_2345, -32'sh6789, 32'sh3_0000, 32'sh1_2345, -32'sh6789, 32'sh3_0000,
			7, 8, 9, 1, 2, 3};
		matrix_q.push_back(pack(m));
		// large translation on small inverse
		m = '{32'sh100_0000, 0, 0, 0, 32'sh100_0000, 0, 0, 0, 32'sh100_0000,
			FX_MIN, FX_MIN, FX_MIN};
		matrix_q.push_back(pack(m));
		// translation row overflow only
		m = '{32'sh0_0100, 0, 0, 0, 32'sh0_0100, 0, 0, 0, 32'sh0_0100,
			32'sh4000_0000, -32'sh4000_0000, 32'sh0100_0000};
		matrix_q.push_back(pack(m));
		for (int i = 0; i < 4; i++) begin
			foreach (m[k]) m[k] = $urandom;
			matrix_q.push_back(pack(m));
		end

		for (int n = 0; n < 295; n++) begin
			kind = $urandom_range(99);
			foreach (m[k]) m[k] = rnd_fx(kind < 55 ? 1 : kind < 70 ? 0 : kind < 80 ? 2 : 3);
			if (kind >= 88 && kind < 94) begin
				// one row a copy of another, or a zero column
				for (int k = 0; k < 3; k++) m[6+k] = m[k];
			end else if (kind >= 94) begin
				for (int k = 0; k < 3; k++) m[k*3+1] = 0;
			end
			if ($urandom_range(9) == 0) begin
				m[9] = $urandom;
				m[10] = $urandom;
				m[11] = $urandom;
			end
			matrix_q.push_back(pack(m));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (matrix_q.size() > 0 || s_tvalid || inverse_rows_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (!failed && inverse_rows_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/aminv_pkg.sv
src/aminv_det.sv
src/aminv_div.sv
src/aminv_xlat.sv
src/aminv_ser.sv
src/affine_matrix_inverse_top.sv
tb/testbench.sv
